// ----- rtl/reception_claim_scoreboard_assert.svh -----
// Assertion helpers for the reception claim scoreboard.
// They expect clk and arst_n in scope.
`ifndef RECEPTION_CLAIM_SCOREBOARD_ASSERT_SVH
`define RECEPTION_CLAIM_SCOREBOARD_ASSERT_SVH

// Same-cycle implication.
`define RCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rcs_pkg.sv -----
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the reception claim scoreboard.
// ----------------------------------------------------------------------------
package rcs_pkg;

	localparam int DEF_REPORT_SLOTS = 4;
	localparam int DEF_MAX_CLAIMS   = 16;
	localparam int MAX_RESULTS      = 16;
	localparam int CNT_OUT_W        = 5;
	localparam int GAP_CNT_W        = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_COVERED = 2'd1,
		ST_EQUAL   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  slot;
		logic [31:0] range_offset;
		logic [31:0] range_length;
		logic [31:0] scope_low;
		logic [31:0] scope_high;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [4:0]  claim_count;
		logic        gap_valid;
		logic [31:0] gap_offset;
		logic [31:0] gap_length;
		logic [31:0] upper_limit;
		logic        last;
	} out_t;

	// one stored range
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
	} entry_t;

	// slot modulo the slot count, by repeated subtraction on a 2-bit value
	function automatic logic [1:0] slot_mod(logic [1:0] s, int r);
		logic [1:0] v;
		v = s;
		for (int i = 0; i < 3; i++) begin
			if (int'(v) >= r) begin
				v = v - 2'(r);
			end
		end
		return v;
	endfunction

endpackage

// ----- rtl/rcs_ram.sv -----
// ----------------------------------------------------------------------------
// rcs_ram
// Range store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcs_ram
	import rcs_pkg::*;
#(
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);

	entry_t mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/rcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcs_ctrl
// Sequencer: scan pass, rewrite-and-merge pass and gap walk over the store.
// ----------------------------------------------------------------------------
module rcs_ctrl
	import rcs_pkg::*;
#(
	parameter int REPORT_SLOTS = DEF_REPORT_SLOTS,
	parameter int MAX_CLAIMS   = DEF_MAX_CLAIMS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	input  logic [31:0] upper,
	output logic        res_valid,
	input  logic        res_ready,
	output out_t        res
);

	localparam int SLOT_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
	localparam int IDX_W  = $clog2(MAX_CLAIMS);
	localparam int CNT_W  = $clog2(MAX_CLAIMS + 1);
	localparam int ADDR_W = SLOT_W + IDX_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_FILL  = 7'b0000100,
		S_FLUSH = 7'b0001000,
		S_REPLY = 7'b0010000,
		S_GAP   = 7'b0100000,
		S_GEND  = 7'b1000000
	} state_t;

	state_t state_q;
	in_t req_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0] held_q [REPORT_SLOTS];
	logic [CNT_W-1:0] n_q, rd_i_q, dat_i_q, g_i_q, pos_q, w_q, cnt_q;
	logic rd_v_q, cov_q, g_v_q, less_q, eq_q, ins_q, acc_v_q, pend_v_q;
	logic [31:0] hi_q, prev_q;
	entry_t acc_q, pend_q;
	status_t st_q;
	logic [GAP_CNT_W-1:0] k_q;

	logic [SLOT_W-1:0] slot_in;
	logic first_ins, accept, take, consume, issue, scan_done;
	logic ins_now, have_elem, joins, found;
	logic [31:0] ent_end;
	entry_t rdata, elem;
	logic we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	entry_t wdata;

	rcs_ram #(.ADDR_W(ADDR_W)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign slot_in   = SLOT_W'(slot_mod(in_data.slot, REPORT_SLOTS));
	assign accept    = in_valid && (state_q == S_IDLE);
	assign first_ins = !in_data.kind && (held_q[slot_in] == '0);
	assign in_stall  = (state_q != S_IDLE);

	assign ent_end   = rdata.start + rdata.size;
	assign scan_done = !rd_v_q && (rd_i_q == n_q);
	assign found     = (rdata.start > prev_q) && (int'(k_q) < MAX_RESULTS);

	// insertion slips in ahead of the entry at pos, or after the last one
	assign ins_now = ins_q && ((rd_v_q && dat_i_q == pos_q) || scan_done);
	assign have_elem = ins_now || rd_v_q;
	always_comb begin
		if (ins_now) begin
			elem = '{start: req_q.range_offset, size: req_q.range_length};
		end else begin
			elem = rdata;
			if (g_v_q && dat_i_q == g_i_q) begin
				elem.size = rdata.size + req_q.range_length;
			end
		end
	end
	assign joins = (acc_q.start + acc_q.size) == elem.start;

	always_comb begin
		case (state_q)
			S_SCAN:  take = 1'b1;
			S_FILL:  take = !ins_now;
			S_GAP:   take = !(found && pend_v_q) || res_ready;
			default: take = 1'b0;
		endcase
	end

	assign consume = rd_v_q && take;
	assign issue   = (state_q inside {S_SCAN, S_FILL, S_GAP}) && (!rd_v_q || consume)
		&& (rd_i_q < n_q);
	assign re    = issue;
	assign raddr = {slot_q, rd_i_q[IDX_W-1:0]};

	always_comb begin
		we    = 1'b0;
		waddr = {slot_q, w_q[IDX_W-1:0]};
		wdata = acc_q;
		case (state_q)
			S_IDLE: begin
				if (accept && first_ins) begin
					we    = 1'b1;
					waddr = {slot_in, IDX_W'(0)};
					wdata = '{start: in_data.range_offset, size: in_data.range_length};
				end
			end
			S_FILL: begin
				we = have_elem && acc_v_q && !joins;
			end
			S_FLUSH: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		case (state_q)
			S_REPLY: begin
				res_valid       = 1'b1;
				res.status      = st_q;
				res.claim_count = CNT_OUT_W'(cnt_q);
				res.last        = 1'b1;
			end
			S_GAP: begin
				res_valid       = rd_v_q && found && pend_v_q;
				res.claim_count = CNT_OUT_W'(n_q);
				res.gap_valid   = 1'b1;
				res.gap_offset  = pend_q.start;
				res.gap_length  = pend_q.size;
				res.upper_limit = upper;
			end
			S_GEND: begin
				res_valid       = 1'b1;
				res.claim_count = CNT_OUT_W'(n_q);
				res.gap_valid   = pend_v_q;
				res.gap_offset  = pend_v_q ? pend_q.start : '0;
				res.gap_length  = pend_v_q ? pend_q.size : '0;
				res.upper_limit = upper;
				res.last        = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_v_q  <= 1'b0;
			for (int i = 0; i < REPORT_SLOTS; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			if (issue) begin
				rd_i_q  <= rd_i_q + 1'b1;
				dat_i_q <= rd_i_q;
				rd_v_q  <= 1'b1;
			end else if (consume) begin
				rd_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q  <= in_data;
						slot_q <= slot_in;
						hi_q   <= in_data.range_offset + in_data.range_length;
						n_q    <= held_q[slot_in];
						rd_i_q <= '0;
						rd_v_q <= 1'b0;
						if (first_ins) begin
							held_q[slot_in] <= CNT_W'(1);
							cnt_q   <= CNT_W'(1);
							st_q    <= ST_OK;
							state_q <= S_REPLY;
						end else if (!in_data.kind) begin
							cov_q   <= 1'b0;
							g_v_q   <= 1'b0;
							less_q  <= 1'b1;
							pos_q   <= '0;
							eq_q    <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							prev_q   <= '0;
							k_q      <= '0;
							pend_v_q <= 1'b0;
							state_q  <= S_GAP;
						end
					end
				end
				S_SCAN: begin
					if (rd_v_q) begin
						if (req_q.range_offset >= rdata.start && req_q.range_offset <= ent_end
							&& hi_q >= rdata.start && hi_q <= ent_end) begin
							cov_q <= 1'b1;
						end
						if (!g_v_q && ent_end == req_q.range_offset) begin
							g_v_q <= 1'b1;
							g_i_q <= dat_i_q;
						end
						if (less_q) begin
							if (rdata.start < req_q.range_offset) begin
								pos_q <= pos_q + 1'b1;
							end else begin
								less_q <= 1'b0;
								eq_q   <= (rdata.start == req_q.range_offset);
							end
						end
					end
					if (scan_done) begin
						cnt_q <= n_q;
						if (cov_q) begin
							st_q    <= ST_COVERED;
							state_q <= S_REPLY;
						end else if (g_v_q || (!eq_q && int'(n_q) < MAX_CLAIMS)) begin
							rd_i_q  <= '0;
							w_q     <= '0;
							acc_v_q <= 1'b0;
							ins_q   <= !g_v_q;
							state_q <= S_FILL;
						end else begin
							st_q    <= eq_q ? ST_EQUAL : ST_FULL;
							state_q <= S_REPLY;
						end
					end
				end
				S_FILL: begin
					if (have_elem) begin
						if (!acc_v_q) begin
							acc_q   <= elem;
							acc_v_q <= 1'b1;
						end else if (joins) begin
							acc_q.size <= acc_q.size + elem.size;
						end else begin
							w_q   <= w_q + 1'b1;
							acc_q <= elem;
						end
					end
					if (ins_now) begin
						ins_q <= 1'b0;
					end
					if (scan_done && !ins_q) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					held_q[slot_q] <= w_q + 1'b1;
					cnt_q   <= w_q + 1'b1;
					st_q    <= ST_OK;
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_GAP: begin
					if (consume) begin
						if (found) begin
							pend_q   <= '{start: prev_q, size: rdata.start - prev_q};
							pend_v_q <= 1'b1;
							k_q      <= k_q + 1'b1;
						end
						prev_q <= ent_end;
					end
					if (scan_done) begin
						state_q <= S_GEND;
					end
				end
				S_GEND: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/reception_claim_scoreboard.sv -----
// ----------------------------------------------------------------------------
// reception_claim_scoreboard
// Per-slot sorted list of received byte ranges with merge and gap reporting.
// Insert: a scan pass and, unless covered or refused, a rewrite pass over the
//   range store (one read a cycle, held while the new range slips in), one result.
// Gap query: one walk over the range store; a hole holds the walk only while the
//   output is stalled. The range store read port sets the pace. One
//   transaction in flight at a time.
// Reset: asynchronous, clears all slot fill counts and the config register;
//   the range store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "reception_claim_scoreboard_assert.svh"

module reception_claim_scoreboard
	import rcs_pkg::*;
#(
	parameter int REPORT_SLOTS = DEF_REPORT_SLOTS,
	parameter int MAX_CLAIMS   = DEF_MAX_CLAIMS
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: reliable part length
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	// requests
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	// results
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data
);

	logic [31:0] red_part_length_q;
	logic res_valid, res_ready;
	out_t res;
	logic out_valid_q;
	out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_part_length_q <= '0;
		end else if (cfg_wr_en) begin
			red_part_length_q <= cfg_wr_data;
		end
	end

	// sequencer plus range store
	rcs_ctrl #(
		.REPORT_SLOTS (REPORT_SLOTS),
		.MAX_CLAIMS   (MAX_CLAIMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.upper     (red_part_length_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: the sequencer goes back to idle as soon as the final
	// result transaction lands here, so the next request can come in while it waits
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// only gap reports can be followed by more results of the same request
	`RCS_ASSERT_IMP(a_mid_is_gap, out_valid && !out_data.last, out_data.gap_valid && out_data.status == ST_OK, "non-final result without a gap")
	// a refused insert reports nothing about gaps
	`RCS_ASSERT_IMP(a_refused_plain, out_valid && out_data.status != ST_OK, !out_data.gap_valid && out_data.upper_limit == '0, "refused insert carries gap data")
	// an accepted request leaves the sequencer busy in the next cycle
	`RCS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request accepted but not busy")

endmodule
